[rtl/sltab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltab_pkg
// Shared constants and codes for the slot table with id lookup and sort.
// ----------------------------------------------------------------------------
package sltab_pkg;

	// Default sizing
	localparam int SLOTS_DEF      = 16;
	localparam int NAME_BYTES_DEF = 8;
	localparam int ID_BITS_DEF    = 16;

	// Port field widths
	localparam int REQ_W    = 3;
	localparam int IDX_W    = 4;
	localparam int NAME_W   = 64;
	localparam int SID_W    = 16;
	localparam int STATUS_W = 3;
	localparam int RID_W    = 16;
	localparam int TSIZE_W  = 5;

	localparam logic [TSIZE_W-1:0] TSIZE_RESET = 5'd16;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_INS_AT   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_FREE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RENAME   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_FIND     = 3'd4;
	localparam logic [REQ_W-1:0] REQ_SORT     = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

endpackage

[rtl/sltab_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltab_mem
// Slot record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sltab_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 80
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/slot_table_with_id_lookup_and_sort.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_with_id_lookup_and_sort
// Slot table with insert, first-free insert, remove, rename, id lookup and a
// stable ascending sort by name. Names and ids live in a one-read, one-write
// memory.
// ----------------------------------------------------------------------------
//  channel | handshake            | beat contents
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | req_type, slot_index, entry_name, search_id
//  out     | out_valid / out_stall| status, result_index, result_id
//  cfg     | cfg_valid / cfg_ready| cfg_data = table_size
//
//  One request at a time. The first-free scan and find walk the slots from
//  index 0 (find with one memory read per slot); L = table_size saturated
//  to 1..SLOTS. Sort runs L-1 passes over the single memory read port.
//  Reset empties every slot and zeroes the id counter; no clearing pass.
//  A stalled result sits in the output register while the next beat enters.
// ----------------------------------------------------------------------------
module slot_table_with_id_lookup_and_sort
	import sltab_pkg::*;
#(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int NAME_BYTES = NAME_BYTES_DEF,
	parameter int ID_BITS    = ID_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [IDX_W-1:0]    slot_index,
	input  logic [NAME_W-1:0]   entry_name,
	input  logic [SID_W-1:0]    search_id,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_W-1:0]    result_index,
	output logic [RID_W-1:0]    result_id,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [TSIZE_W-1:0]  cfg_data
);

	localparam int IW   = $clog2(SLOTS);
	localparam int CW   = $clog2(SLOTS + 1);
	localparam int MW   = NAME_W + ID_BITS;
	localparam int CMPW = (ID_BITS > SID_W) ? ID_BITS : SID_W;
	localparam logic [NAME_W-1:0] NAME_MASK = ~(NAME_W'(0)) << (NAME_W - 8 * NAME_BYTES);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_SCAN = 11'b000_0000_0010,
		S_RDSL = 11'b000_0000_0100,
		S_FRD  = 11'b000_0000_1000,
		S_FCK  = 11'b000_0001_0000,
		S_SA   = 11'b000_0010_0000,
		S_SB   = 11'b000_0100_0000,
		S_SC   = 11'b000_1000_0000,
		S_SD   = 11'b001_0000_0000,
		S_SE   = 11'b010_0000_0000,
		S_DONE = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [TSIZE_W-1:0]  tsize_q;
	logic [SLOTS-1:0]    occ_q;
	logic [SLOTS-1:0]    nv_q;
	logic [ID_BITS-1:0]  ctr_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       pass_q;
	logic [REQ_W-1:0]    req_q;
	logic [IW-1:0]       idx_q;
	logic [NAME_W-1:0]   name_q;
	logic [SID_W-1:0]    sid_q;
	logic                car_occ_q;
	logic                car_nv_q;
	logic [NAME_W-1:0]   car_name_q;
	logic [ID_BITS-1:0]  car_id_q;
	logic [STATUS_W-1:0] res_st_q;
	logic [IDX_W-1:0]    res_ix_q;
	logic [RID_W-1:0]    res_id_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    result_index_q;
	logic [RID_W-1:0]    result_id_q;

	logic [CW-1:0]      lim;
	logic               in_fire;
	logic [IW-1:0]      in_ix;
	logic [IW-1:0]      cnt_ix;
	logic               bad_ix;
	logic               exh;
	logic [ID_BITS-1:0] new_id;
	logic [IW-1:0]      rd_addr;
	logic               occ_at;
	logic               nv_at;
	logic [MW-1:0]      rd_data;
	logic [NAME_W-1:0]  rd_name;
	logic [ID_BITS-1:0] rd_id;
	logic [NAME_W-1:0]  nxt_name;
	logic [NAME_W-1:0]  car_name;
	logic               swap;
	logic               last_cnt;
	logic               out_free;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic [NAME_W-1:0]  wr_name;
	logic [ID_BITS-1:0] wr_id;
	logic               wr_occ;
	logic               wr_nv;
	logic               clr_en;
	logic               fill;

	// Saturate the slot count to 1..SLOTS
	always_comb begin
		if (tsize_q == '0) begin
			lim = CW'(1);
		end else if (int'(tsize_q) > SLOTS) begin
			lim = CW'(SLOTS);
		end else begin
			lim = CW'(tsize_q);
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign in_ix     = IW'(slot_index);
	assign cnt_ix    = cnt_q[IW-1:0];
	assign bad_ix    = int'(slot_index) >= int'(lim);
	assign exh       = (ctr_q == '1);
	assign new_id    = ctr_q + ID_BITS'(1);
	assign last_cnt  = ((cnt_q + CW'(1)) == lim);
	assign out_free  = !out_valid_q || !out_stall;

	// Single read address for memory and flag vectors
	assign rd_addr = (state_q == S_IDLE) ? in_ix : cnt_ix;
	assign occ_at  = occ_q[rd_addr];
	assign nv_at   = nv_q[rd_addr];
	assign rd_name = rd_data[MW-1 -: NAME_W];
	assign rd_id   = rd_data[ID_BITS-1:0];

	// Names of never-written slots read as zero
	assign nxt_name = nv_at ? rd_name : '0;
	assign car_name = car_nv_q ? car_name_q : '0;
	assign swap     = car_name > nxt_name;
	assign fill     = wr_en && ((state_q == S_IDLE) || (state_q == S_SCAN));

	// Select the write for this cycle
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_ix;
		wr_name = name_q;
		wr_id   = new_id;
		wr_occ  = 1'b1;
		wr_nv   = 1'b1;
		clr_en  = 1'b0;
		case (state_q)
			S_IDLE: begin
				wr_addr = in_ix;
				wr_name = entry_name & NAME_MASK;
				wr_en   = in_fire && (req_type == REQ_INS_AT) && !bad_ix && !occ_at && !exh;
			end
			S_SCAN: begin
				wr_en = !occ_at && !exh;
			end
			S_RDSL: begin
				wr_addr = idx_q;
				wr_id   = rd_id;
				wr_en   = (req_q == REQ_RENAME);
				clr_en  = (req_q == REQ_REMOVE);
			end
			S_SD: begin
				wr_en   = 1'b1;
				wr_addr = IW'(cnt_q - CW'(1));
				wr_name = swap ? rd_name : car_name_q;
				wr_id   = swap ? rd_id : car_id_q;
				wr_occ  = swap ? occ_at : car_occ_q;
				wr_nv   = swap ? nv_at : car_nv_q;
			end
			S_SE: begin
				wr_en   = 1'b1;
				wr_addr = IW'(lim - CW'(1));
				wr_name = car_name_q;
				wr_id   = car_id_q;
				wr_occ  = car_occ_q;
				wr_nv   = car_nv_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	sltab_mem #(
		.DEPTH (SLOTS),
		.WIDTH (MW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({wr_name, wr_id}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Hold the slot size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= TSIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tsize_q <= cfg_data;
		end
	end

	// Update occupancy, written marks and the id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			nv_q  <= '0;
			ctr_q <= '0;
		end else begin
			if (wr_en) begin
				occ_q[wr_addr] <= wr_occ;
				nv_q[wr_addr]  <= wr_nv;
			end
			if (clr_en) begin
				occ_q[idx_q] <= 1'b0;
			end
			if (fill) begin
				ctr_q <= new_id;
			end
		end
	end

	// Sequence one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pass_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q  <= '0;
					pass_q <= CW'(1);
					if (in_fire) begin
						case (req_type)
							REQ_INS_FREE: state_q <= S_SCAN;
							REQ_REMOVE,
							REQ_RENAME:   state_q <= (bad_ix || !occ_at) ? S_DONE : S_RDSL;
							REQ_FIND:     state_q <= S_FRD;
							REQ_SORT:     state_q <= (lim == CW'(1)) ? S_DONE : S_SA;
							default:      state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (!occ_at || last_cnt) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_RDSL: state_q <= S_DONE;
				S_FRD:  state_q <= S_FCK;
				S_FCK: begin
					if ((occ_at && (CMPW'(rd_id) == CMPW'(sid_q))) || last_cnt) begin
						state_q <= S_DONE;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_FRD;
					end
				end
				S_SA: state_q <= S_SB;
				S_SB: begin
					cnt_q   <= CW'(1);
					state_q <= S_SC;
				end
				S_SC: state_q <= S_SD;
				S_SD: begin
					if (last_cnt) begin
						state_q <= S_SE;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_SC;
					end
				end
				S_SE: begin
					cnt_q <= '0;
					if ((pass_q + CW'(1)) == lim) begin
						state_q <= S_DONE;
					end else begin
						pass_q  <= pass_q + CW'(1);
						state_q <= S_SA;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Latch request fields, carry record and result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					req_q  <= req_type;
					idx_q  <= in_ix;
					name_q <= entry_name & NAME_MASK;
					sid_q  <= search_id;
					case (req_type)
						REQ_INS_AT: begin
							if (!bad_ix && !occ_at && !exh) begin
								res_st_q <= ST_OK;
								res_ix_q <= slot_index;
								res_id_q <= RID_W'(new_id);
							end else begin
								res_st_q <= (!bad_ix && !occ_at) ? ST_EXHAUSTED : ST_BAD;
								res_ix_q <= '0;
								res_id_q <= '0;
							end
						end
						REQ_SORT: begin
							res_st_q <= ST_OK;
							res_ix_q <= '0;
							res_id_q <= '0;
						end
						default: begin
							res_st_q <= ST_BAD;
							res_ix_q <= '0;
							res_id_q <= '0;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (!occ_at) begin
					if (exh) begin
						res_st_q <= ST_EXHAUSTED;
					end else begin
						res_st_q <= ST_OK;
						res_ix_q <= IDX_W'(cnt_q);
						res_id_q <= RID_W'(new_id);
					end
				end else if (last_cnt) begin
					res_st_q <= ST_FULL;
				end
			end
			S_RDSL: begin
				res_st_q <= ST_OK;
				res_id_q <= RID_W'(rd_id);
			end
			S_FCK: begin
				if (occ_at && (CMPW'(rd_id) == CMPW'(sid_q))) begin
					res_st_q <= ST_OK;
					res_ix_q <= IDX_W'(cnt_q);
					res_id_q <= RID_W'(rd_id);
				end else if (last_cnt) begin
					res_st_q <= ST_NOTFOUND;
				end
			end
			S_SB: begin
				car_occ_q  <= occ_at;
				car_nv_q   <= nv_at;
				car_name_q <= rd_name;
				car_id_q   <= rd_id;
			end
			S_SD: begin
				if (!swap) begin
					car_occ_q  <= occ_at;
					car_nv_q   <= nv_at;
					car_name_q <= rd_name;
					car_id_q   <= rd_id;
				end
			end
			default: begin
				res_st_q <= res_st_q;
			end
		endcase
	end

	// Drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			status_q       <= res_st_q;
			result_index_q <= res_ix_q;
			result_id_q    <= res_id_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_index = result_index_q;
	assign result_id    = result_id_q;

endmodule

[rtl/sltab_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltab_chk
// Port-level checks for the slot table, bound to the top level.
// ----------------------------------------------------------------------------
module sltab_chk
	import sltab_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic [REQ_W-1:0]    req_type,
	input logic [IDX_W-1:0]    slot_index,
	input logic [NAME_W-1:0]   entry_name,
	input logic [SID_W-1:0]    search_id,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [IDX_W-1:0]    result_index,
	input logic [RID_W-1:0]    result_id,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [TSIZE_W-1:0]  cfg_data
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_id))
		else $error("stalled result beat changed");

	// Take one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	// Report zero index and id on every error
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (result_index == '0) && (result_id == '0))
		else $error("error result carries index or id");

	// Report only defined status codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_BAD) || (status == ST_FULL) ||
			(status == ST_NOTFOUND) || (status == ST_EXHAUSTED))
		else $error("undefined status code");

endmodule

bind slot_table_with_id_lookup_and_sort sltab_chk u_sltab_chk (.*);

[test/slot_table_with_id_lookup_and_sort_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_with_id_lookup_and_sort_chk
// Watches the request, result and size-write channels of the slot table.
// Keeps its own copy of the slots, predicts one result per accepted request
// and compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module slot_table_with_id_lookup_and_sort_chk
	import sltab_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [IDX_W-1:0]    slot_index,
	input  logic [NAME_W-1:0]   entry_name,
	input  logic [SID_W-1:0]    search_id,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [IDX_W-1:0]    result_index,
	input  logic [RID_W-1:0]    result_id,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [TSIZE_W-1:0]  cfg_data,
	output int                  fails,
	output int                  pending
);

	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic [IDX_W-1:0]    idx;
		logic [RID_W-1:0]    id;
	} slot_reply_t;

	localparam logic [RID_W-1:0] ID_TOP = '1;

	logic                occ [SLOTS_DEF];
	logic [NAME_W-1:0]   nm  [SLOTS_DEF];
	logic [RID_W-1:0]    sid [SLOTS_DEF];
	logic [RID_W-1:0]    last_id;
	logic [TSIZE_W-1:0]  tsize;
	slot_reply_t         replies_due[$];

	function automatic int span();
		if (tsize < 1) return 1;
		if (tsize > SLOTS_DEF) return SLOTS_DEF;
		return int'(tsize);
	endfunction

	function automatic logic [RID_W-1:0] fill(int i, logic [NAME_W-1:0] n);
		last_id = last_id + 1'b1;
		nm[i]  = n;
		sid[i] = last_id;
		occ[i] = 1'b1;
		return last_id;
	endfunction

	// Apply one request to the slot copy and return its reply
	function automatic slot_reply_t serve(logic [REQ_W-1:0] rq, logic [IDX_W-1:0] ix,
			logic [NAME_W-1:0] n, logic [SID_W-1:0] key);
		int lim, i, p;
		logic             to;
		logic [NAME_W-1:0] tn;
		logic [RID_W-1:0]  ti;
		slot_reply_t r;
		lim = span();
		r = '{st: ST_BAD, idx: '0, id: '0};
		case (rq)
		REQ_INS_AT: begin
			if (int'(ix) < lim && !occ[ix]) begin
				if (last_id == ID_TOP) r.st = ST_EXHAUSTED;
				else r = '{st: ST_OK, idx: ix, id: fill(int'(ix), n)};
			end
		end
		REQ_INS_FREE: begin
			for (i = 0; i < lim; i++)
				if (!occ[i]) break;
			if (i >= lim) r.st = ST_FULL;
			else if (last_id == ID_TOP) r.st = ST_EXHAUSTED;
			else r = '{st: ST_OK, idx: IDX_W'(i), id: fill(i, n)};
		end
		REQ_REMOVE: begin
			if (int'(ix) < lim && occ[ix]) begin
				occ[ix] = 1'b0;
				r = '{st: ST_OK, idx: '0, id: sid[ix]};
			end
		end
		REQ_RENAME: begin
			if (int'(ix) < lim && occ[ix]) begin
				nm[ix] = n;
				r = '{st: ST_OK, idx: '0, id: sid[ix]};
			end
		end
		REQ_FIND: begin
			for (i = 0; i < lim; i++)
				if (occ[i] && sid[i] == key) break;
			if (i >= lim) r.st = ST_NOTFOUND;
			else r = '{st: ST_OK, idx: IDX_W'(i), id: sid[i]};
		end
		REQ_SORT: begin
			// Stable bubble sort moving whole slots, empty ones too
			for (p = 1; p < lim; p++)
				for (i = 0; i + 1 < lim; i++)
					if (nm[i] > nm[i+1]) begin
						to = occ[i]; tn = nm[i]; ti = sid[i];
						occ[i] = occ[i+1]; nm[i] = nm[i+1]; sid[i] = sid[i+1];
						occ[i+1] = to; nm[i+1] = tn; sid[i+1] = ti;
					end
			r.st = ST_OK;
		end
		default: ;
		endcase
		return r;
	endfunction

	// Track size writes, predict on request beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		slot_reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS_DEF; i++) begin
				occ[i] = 1'b0;
				nm[i]  = '0;
				sid[i] = '0;
			end
			last_id = '0;
			tsize   = TSIZE_RESET;
			replies_due.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				tsize = cfg_data;
			if (in_valid && !in_stall)
				replies_due.push_back(serve(req_type, slot_index, entry_name, search_id));
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("result beat with nothing expected: status %0d index %0d id %0d",
						status, result_index, result_id);
					fails <= fails + 1;
				end else begin
					want = replies_due.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fails <= fails + 1;
					end else if (result_index !== want.idx) begin
						$error("result_index: expected %0d, got %0d", want.idx, result_index);
						fails <= fails + 1;
					end else if (result_id !== want.id) begin
						$error("result_id: expected %0d, got %0d", want.id, result_id);
						fails <= fails + 1;
					end
				end
			end
			pending <= replies_due.size();
		end
	end

endmodule

[test/slot_table_with_id_lookup_and_sort_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_with_id_lookup_and_sort_tb
// Drives the slot table with a directed opening, random request mixes over
// several table sizes (saturating ones included), a long result hold-off and
// a final back-to-back run on a one-slot table. The checker judges every beat.
// ----------------------------------------------------------------------------
module slot_table_with_id_lookup_and_sort_tb;
	import sltab_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [REQ_W-1:0]    req_type = REQ_FIND;
	logic [IDX_W-1:0]    slot_index = '0;
	logic [NAME_W-1:0]   entry_name = '0;
	logic [SID_W-1:0]    search_id = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    result_index;
	logic [RID_W-1:0]    result_id;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [TSIZE_W-1:0]  cfg_data = TSIZE_RESET;
	int                  fails;
	int                  pending;

	bit hold_req = 1'b0;
	bit quiet = 1'b0;
	int burst_left = 0;
	int cur_size = 16;
	int ins_sent = 0;

	always #6 clk = ~clk;

	slot_table_with_id_lookup_and_sort dut (.*);

	slot_table_with_id_lookup_and_sort_chk chk (.*);

	initial begin
		#60ms;
		$display("FAIL slot_table_with_id_lookup_and_sort");
		$finish;
	end

	// Receiver: stall pattern in segments, long hold on request, none when quiet
	initial begin
		int seg, level;
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				seg   = $urandom_range(1, 40);
				level = $urandom_range(0, 3);
				repeat (seg) begin
					out_stall <= !quiet && (level != 0) && ($urandom_range(0, 9) < 3 * level);
					@(posedge clk);
				end
			end
		end
	end

	// Offer one request beat and hold it until accepted
	task automatic send(logic [REQ_W-1:0] rq, logic [IDX_W-1:0] ix,
			logic [NAME_W-1:0] n, logic [SID_W-1:0] key);
		in_valid   <= 1'b1;
		req_type   <= rq;
		slot_index <= ix;
		entry_name <= n;
		search_id  <= key;
		if (rq == REQ_INS_AT || rq == REQ_INS_FREE) ins_sent++;
		do @(posedge clk); while (in_stall);
		// Keep going within a burst, else drop valid for a random gap
		if (burst_left > 0) begin
			burst_left--;
		end else if (!quiet) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
		end
	endtask

	// Wait for every result, then write the table size
	task automatic write_size(logic [TSIZE_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_size = (v < 1) ? 1 : (v > 16) ? 16 : int'(v);
	endtask

	function automatic logic [NAME_W-1:0] pick_name();
		case ($urandom_range(0, 5))
		0: return {$urandom, $urandom};
		1: return '0;
		2: return '1;
		3: return {8'($urandom_range(8'h61, 8'h63)), 56'd0};
		4: return {8'($urandom_range(8'h61, 8'h62)), 8'($urandom_range(8'h61, 8'h62)), 48'd0};
		default: return {8'($urandom), 56'd0};
		endcase
	endfunction

	task automatic random_phase(int count);
		int w;
		logic [REQ_W-1:0] rq;
		logic [IDX_W-1:0] ix;
		logic [SID_W-1:0] key;
		repeat (count) begin
			w = $urandom_range(0, 99);
			if (w < 20) rq = REQ_INS_AT;
			else if (w < 40) rq = REQ_INS_FREE;
			else if (w < 58) rq = REQ_REMOVE;
			else if (w < 70) rq = REQ_RENAME;
			else if (w < 90) rq = REQ_FIND;
			else if (w < 95) rq = REQ_SORT;
			else rq = REQ_W'($urandom_range(6, 7));
			ix  = ($urandom_range(0, 4) != 0) ? IDX_W'($urandom_range(0, cur_size - 1))
				: IDX_W'($urandom);
			key = ($urandom_range(0, 4) != 0) ? SID_W'($urandom_range(0, ins_sent + 1))
				: SID_W'($urandom);
			send(rq, ix, pick_name(), key);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at full size
		send(REQ_INS_FREE, 4'd0,  '1, '0);
		send(REQ_INS_AT,   4'd15, '0, '0);
		send(REQ_INS_AT,   4'd15, 64'h4142_0000_0000_0000, '0);
		send(REQ_REMOVE,   4'd3,  '0, '0);
		send(REQ_RENAME,   4'd3,  '1, '0);
		send(REQ_FIND,     4'd0,  '0, 16'd1);
		send(REQ_FIND,     4'd0,  '0, 16'd0);
		send(REQ_FIND,     4'd0,  '0, 16'hFFFF);
		send(REQ_INS_AT,   4'd7,  64'h6100_0000_0000_0000, '0);
		send(REQ_INS_AT,   4'd8,  64'h6100_0000_0000_0000, '0);
		send(REQ_RENAME,   4'd15, 64'h0102_0304_0506_0708, '0);
		send(REQ_SORT,     4'd0,  '0, '0);
		send(REQ_FIND,     4'd0,  '0, 16'd2);
		send(REQ_REMOVE,   4'd0,  '0, '0);
		send(REQ_REMOVE,   4'd15, '0, '0);
		send(REQ_FIND,     4'd0,  '0, 16'd4);
		send(3'd6,         4'd0,  '0, '0);
		send(3'd7,         4'd15, '1, '1);

		// Random mixes over several sizes
		random_phase(300);
		write_size(5'd1);
		random_phase(150);
		write_size(5'd5);
		random_phase(250);

		// Long result hold-off while requests keep coming, then mixes over more sizes, saturating values included
		hold_req = 1'b1;
		burst_left = 60;
		random_phase(60);
		write_size(5'd31);
		random_phase(300);
		write_size(5'd0);
		random_phase(100);
		write_size(5'd8);
		random_phase(300);
		write_size(5'd16);
		random_phase(300);

		// Insert and remove back to back on a one-slot table
		write_size(5'd1);
		quiet = 1'b1;
		burst_left = 1 << 30;
		send(REQ_REMOVE, 4'd0, '0, '0);
		repeat (30) begin
			send(REQ_INS_AT, 4'd0, {$urandom, $urandom}, '0);
			send(REQ_REMOVE, 4'd0, '0, '0);
		end
		send(REQ_INS_FREE, 4'd0, '1, '0);
		send(REQ_FIND, 4'd0, '0, 16'hFFFF);

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("PASS slot_table_with_id_lookup_and_sort");
		else
			$display("FAIL slot_table_with_id_lookup_and_sort");
		$finish;
	end

endmodule

[filelist.f]
rtl/sltab_pkg.sv
rtl/sltab_mem.sv
rtl/slot_table_with_id_lookup_and_sort.sv
rtl/sltab_chk.sv
test/slot_table_with_id_lookup_and_sort_chk.sv
test/slot_table_with_id_lookup_and_sort_tb.sv
